// ===== rtl/videotex_text_to_utf8_assert.svh =====
// ---------------------------------------------------------------------------
// assertion macros used by the converter rtl
// ---------------------------------------------------------------------------
`ifndef VIDEOTEX_TEXT_TO_UTF8_ASSERT_SVH
`define VIDEOTEX_TEXT_TO_UTF8_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define VT2U_ASSERT_IMP(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error("vt2u: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define VT2U_ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error("vt2u: next-cycle check failed");

`endif

// ===== rtl/vt2u_pkg.sv =====
// ---------------------------------------------------------------------------
// vt2u_pkg
// types and constants shared by the terminal text to utf-8 converter
// ---------------------------------------------------------------------------
package vt2u_pkg;

    localparam int RUN_MAX   = 6;
    localparam int RUN_LEN_W = 3;

    // one classified input byte: up to six output bytes, first in data[0]
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] data;
        logic [RUN_LEN_W-1:0]    len;
        logic                    eot;
    } run_t;

endpackage

// ===== rtl/vt2u_if.sv =====
// ---------------------------------------------------------------------------
// vt2u channel interfaces
// valid/ready channels for text bytes in and utf-8 bytes out
// ---------------------------------------------------------------------------
interface vt2u_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface vt2u_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_text;

    modport source (output valid, output out_byte, output last_of_run,
                    output end_of_text, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input end_of_text, output ready);
endinterface

// ===== rtl/vt2u_front.sv =====
// ---------------------------------------------------------------------------
// vt2u_front
// takes text bytes, tracks the sequence mode and turns each byte into a run; sequence bytes give none
// ---------------------------------------------------------------------------
module vt2u_front (
    input  logic          clk,
    input  logic          rst_n,
    vt2u_in_if.sink       text_in,
    output logic          push_valid,
    output vt2u_pkg::run_t push_run,
    input  logic          push_ready
);
    import vt2u_pkg::*;

    typedef enum logic [3:0] {
        MODE_NORMAL = 4'd0,
        MODE_ACCENT = 4'd1,
        MODE_GRAVE  = 4'd2,
        MODE_ACUTE  = 4'd3,
        MODE_CIRC   = 4'd4,
        MODE_UML    = 4'd5,
        MODE_CEDIL  = 4'd6,
        MODE_ESC    = 4'd7,
        MODE_CUR1   = 4'd8,
        MODE_CUR2   = 4'd9
    } mode_t;

    localparam logic [7:0] CODE_ACCENT = 8'h16;
    localparam logic [7:0] CODE_ESC    = 8'h1B;
    localparam logic [7:0] CODE_CURSOR = 8'h1F;
    localparam logic [7:0] CODE_SPACE  = 8'h20;
    localparam logic [7:0] CODE_HASH   = 8'h23;

    function automatic run_t run1(input logic [7:0] b0);
        run_t r;
        r      = '0;
        r.data[0] = b0;
        r.len  = RUN_LEN_W'(1);
        return r;
    endfunction

    function automatic run_t run2(input logic [7:0] b0, input logic [7:0] b1);
        run_t r;
        r      = '0;
        r.data[0] = b0;
        r.data[1] = b1;
        r.len  = RUN_LEN_W'(2);
        return r;
    endfunction

    function automatic run_t run3(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2);
        run_t r;
        r      = '0;
        r.data[0] = b0;
        r.data[1] = b1;
        r.data[2] = b2;
        r.len  = RUN_LEN_W'(3);
        return r;
    endfunction

    // glyphs behind a byte-order mark
    function automatic run_t run_bom(input logic [7:0] b4, input logic [7:0] b5);
        run_t r;
        r      = '0;
        r.data[0] = 8'hEF;
        r.data[1] = 8'hBB;
        r.data[2] = 8'hBF;
        r.data[3] = 8'hE2;
        r.data[4] = b4;
        r.data[5] = b5;
        r.len  = RUN_LEN_W'(6);
        return r;
    endfunction

    function automatic run_t plain_run(input logic [7:0] b);
        run_t r;
        if (b == 8'h60)
        begin
            r = run_bom(8'h80, 8'h92);
        end
        else if (b == 8'h7E)
        begin
            r = run_bom(8'h80, 8'hBE);
        end
        else if (b == 8'h7F)
        begin
            r = run_bom(8'h96, 8'h88);
        end
        else if (b >= 8'h20)
        begin
            r = (b <= 8'h7F) ? run1(b) : run1(8'h3F);
        end
        else
        begin
            r = run1(8'h3F);
        end
        return r;
    endfunction

    // tails for grave, acute, circumflex, diaeresis packed low to high
    function automatic logic [31:0] vowel_tails(input logic [7:0] b);
        logic [31:0] t;
        case (b)
            8'h61:   t = 32'hA4A2A1A0;
            8'h65:   t = 32'hABAAA9A8;
            8'h69:   t = 32'hAFAEADAC;
            8'h6F:   t = 32'hB6B4B3B2;
            8'h75:   t = 32'hBCBBBAB9;
            8'h41:   t = 32'h84828180;
            8'h45:   t = 32'h8B8A8988;
            8'h49:   t = 32'h8F8E8D8C;
            8'h4F:   t = 32'h96949392;
            8'h55:   t = 32'h9C9B9A99;
            default: t = 32'h0;
        endcase
        return t;
    endfunction

    function automatic run_t symbol_run(input logic [7:0] b);
        run_t r;
        case (b)
            8'h23:   r = run2(8'hC2, 8'hA3);
            8'h24:   r = run1(8'h24);
            8'h26:   r = run1(8'h23);
            8'h2C:   r = run3(8'hE2, 8'h86, 8'h90);
            8'h2D:   r = run3(8'hE2, 8'h86, 8'h91);
            8'h2E:   r = run3(8'hE2, 8'h86, 8'h92);
            8'h2F:   r = run3(8'hE2, 8'h86, 8'h93);
            8'h30:   r = run2(8'hC2, 8'hB0);
            8'h31:   r = run2(8'hC2, 8'hB1);
            8'h38:   r = run2(8'hC3, 8'hB7);
            8'h3C:   r = run2(8'hC2, 8'hBC);
            8'h3D:   r = run2(8'hC2, 8'hBD);
            8'h3E:   r = run2(8'hC2, 8'hBE);
            8'h6A:   r = run2(8'hC5, 8'h92);
            8'h7A:   r = run2(8'hC5, 8'h93);
            8'h7B:   r = run2(8'hC3, 8'h9F);
            8'h27:   r = run2(8'hC2, 8'hA7);
            default: r = '0;
        endcase
        return r;
    endfunction

    mode_t       mode_reg;
    mode_t       mode_next;
    run_t        run;
    logic [7:0]  b;
    logic [31:0] tails;
    logic [1:0]  tail_sel;
    logic        accept;

    assign b        = text_in.in_byte;
    assign tails    = vowel_tails(b);
    assign tail_sel = 2'(mode_reg - MODE_GRAVE);

    always_comb
    begin
        mode_next = MODE_NORMAL;
        run       = '0;
        if (b == 8'h00)
        begin
            run     = run1(8'h00);
            run.eot = 1'b1;
        end
        else
        begin
            case (mode_reg)
                MODE_ACCENT:
                begin
                    case (b)
                        8'h41:   mode_next = MODE_GRAVE;
                        8'h42:   mode_next = MODE_ACUTE;
                        8'h43:   mode_next = MODE_CIRC;
                        8'h48:   mode_next = MODE_UML;
                        8'h4B:   mode_next = MODE_CEDIL;
                        default: run = symbol_run(b);
                    endcase
                end
                MODE_GRAVE, MODE_ACUTE, MODE_CIRC, MODE_UML:
                begin
                    if (tails != 32'h0)
                    begin
                        run = run2(8'hC3, tails[8*tail_sel +: 8]);
                    end
                    else
                    begin
                        run = plain_run(b);
                    end
                end
                MODE_CEDIL:
                begin
                    if (b == 8'h63)
                    begin
                        run = run2(8'hC3, 8'hA7);
                    end
                    else if (b == 8'h43)
                    begin
                        run = run2(8'hC3, 8'h87);
                    end
                    else
                    begin
                        run = plain_run(b);
                    end
                end
                MODE_ESC:
                begin
                    if (b == CODE_SPACE || b == CODE_HASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                end
                MODE_CUR1:
                begin
                    mode_next = MODE_CUR2;
                end
                MODE_CUR2:
                begin
                    mode_next = MODE_NORMAL;
                end
                default:
                begin
                    case (b)
                        CODE_ACCENT: mode_next = MODE_ACCENT;
                        CODE_ESC:    mode_next = MODE_ESC;
                        CODE_CURSOR: mode_next = MODE_CUR1;
                        default:     run = plain_run(b);
                    endcase
                end
            endcase
        end
    end

    assign text_in.ready = push_ready;
    assign accept        = text_in.valid && push_ready;
    assign push_valid    = accept && (run.len != '0);
    assign push_run      = run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

// ===== rtl/vt2u_queue.sv =====
// ---------------------------------------------------------------------------
// vt2u_queue
// short queue of classified runs between the front and back parts
// ---------------------------------------------------------------------------
module vt2u_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  vt2u_pkg::run_t push_run,
    output logic           push_ready,
    output logic           pop_valid,
    output vt2u_pkg::run_t pop_run,
    input  logic           pop_ready
);
    import vt2u_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    run_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_run    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/vt2u_back.sv =====
// ---------------------------------------------------------------------------
// vt2u_back
// unpacks queued runs into single utf-8 bytes behind an output register
// ---------------------------------------------------------------------------
`include "videotex_text_to_utf8_assert.svh"

module vt2u_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    input  vt2u_pkg::run_t pop_run,
    output logic           pop_ready,
    vt2u_out_if.source     utf8_out
);
    import vt2u_pkg::*;

    run_t                 cur_reg;
    logic                 cur_valid_reg;
    logic [RUN_LEN_W-1:0] idx_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;
    logic                 out_eot_reg;

    logic advance;
    logic load_out;
    logic cur_last;
    logic cur_free;

    assign advance   = !out_valid_reg || utf8_out.ready;
    assign load_out  = cur_valid_reg && advance;
    assign cur_last  = (idx_reg == cur_reg.len - RUN_LEN_W'(1));
    // current run slot frees up once its final byte moves to the output
    assign cur_free  = !cur_valid_reg || (load_out && cur_last);
    assign pop_ready = cur_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= load_out;
            end
            if (cur_free)
            begin
                cur_valid_reg <= pop_valid;
                idx_reg       <= '0;
            end
            else if (load_out)
            begin
                idx_reg <= idx_reg + RUN_LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cur_free && pop_valid)
        begin
            cur_reg <= pop_run;
        end
        if (load_out)
        begin
            out_byte_reg <= cur_reg.data[idx_reg];
            out_last_reg <= cur_last;
            out_eot_reg  <= cur_reg.eot;
        end
    end

    assign utf8_out.valid       = out_valid_reg;
    assign utf8_out.out_byte    = out_byte_reg;
    assign utf8_out.last_of_run = out_last_reg;
    assign utf8_out.end_of_text = out_eot_reg;

    `VT2U_ASSERT_IMP(a_eot_is_last, clk, rst_n, out_valid_reg && out_eot_reg, out_last_reg)
    `VT2U_ASSERT_IMP(a_idx_in_run, clk, rst_n, cur_valid_reg, idx_reg < cur_reg.len)
    `VT2U_ASSERT_NEXT(a_slot_drains, clk, rst_n, load_out && cur_last && !pop_valid, !cur_valid_reg)

endmodule

// ===== rtl/videotex_text_to_utf8.sv =====
// ---------------------------------------------------------------------------
// videotex_text_to_utf8
// converts 8-bit terminal text with accent and escape sequences to utf-8
// ---------------------------------------------------------------------------
//  channel    dir   payload                                   use
//  text_in    in    in_byte[7:0]                              one text byte
//  utf8_out   out   out_byte[7:0], last_of_run, end_of_text   one utf-8 byte
//
//  text_in takes one byte per cycle while the run queue has room
//  utf8_out gives one byte per cycle while utf8_out.ready is high; a byte that yields
//  several bytes holds the back part until all are out, so the queue depth sets how far the input runs ahead
//  the first byte of a run passes through the queue, the run slot and the output register
//  reset puts the decoder in normal text mode and empties the queue
//  a stall on utf8_out backs up only through the queue to text_in.ready
// ---------------------------------------------------------------------------
module videotex_text_to_utf8 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    vt2u_in_if.sink     text_in,
    vt2u_out_if.source  utf8_out
);
    import vt2u_pkg::*;

    logic push_valid;
    logic push_ready;
    run_t push_run;
    logic pop_valid;
    logic pop_ready;
    run_t pop_run;

    vt2u_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .push_valid (push_valid),
        .push_run   (push_run),
        .push_ready (push_ready)
    );

    vt2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_run   (push_run),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_run    (pop_run),
        .pop_ready  (pop_ready)
    );

    vt2u_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_run   (pop_run),
        .pop_ready (pop_ready),
        .utf8_out  (utf8_out)
    );

endmodule

// ===== tb/sv/tb_videotex_text_to_utf8.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_videotex_text_to_utf8
// self-checking bench for the terminal text to utf-8 converter: text bytes
// go in through a valid/ready channel with random gaps, a local decoder
// predicts the utf-8 bytes of each one, and every output transfer taken
// under random stalls is compared in order against that prediction
// ---------------------------------------------------------------------------
module tb_videotex_text_to_utf8;

    // control and special text bytes
    localparam logic [7:0] CH_EOT      = 8'h00;
    localparam logic [7:0] CH_ACCENT   = 8'h16;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_CURSOR   = 8'h1F;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_BACKTICK = 8'h60;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_DEL      = 8'h7F;

    // letter table selectors after the accent byte
    localparam logic [7:0] KEY_GRAVE = 8'h41;
    localparam logic [7:0] KEY_ACUTE = 8'h42;
    localparam logic [7:0] KEY_CIRC  = 8'h43;
    localparam logic [7:0] KEY_UML   = 8'h48;
    localparam logic [7:0] KEY_CEDIL = 8'h4B;

    typedef enum logic [3:0] {
        MODE_NORMAL,
        MODE_ACCENT,
        MODE_GRAVE,
        MODE_ACUTE,
        MODE_CIRC,
        MODE_UML,
        MODE_CEDIL,
        MODE_ESC,
        MODE_CUR1,
        MODE_CUR2
    } text_mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_text;
    } utf8_beat_t;

    logic clk;
    logic rst_n;

    vt2u_in_if  text_in_if ();
    vt2u_out_if utf8_out_if ();

    videotex_text_to_utf8 DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in_if),
        .utf8_out (utf8_out_if)
    );

    text_mode_t text_mode;
    logic [7:0] utf8_run[$];
    utf8_beat_t pending_utf8[$];
    int         error_count     = 0;
    int         text_bytes_sent = 0;
    bit         sender_idle_on  = 1'b1;
    bit         sink_stall_on   = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------
    function automatic void add_bytes(input int count, input logic [7:0] b0,
                                      input logic [7:0] b1, input logic [7:0] b2);
        if (count > 0)
            utf8_run.push_back(b0);
        if (count > 1)
            utf8_run.push_back(b1);
        if (count > 2)
            utf8_run.push_back(b2);
    endfunction

    function automatic void glyph_bytes(input logic [7:0] b);
        if (b == CH_BACKTICK || b == CH_TILDE || b == CH_DEL)
        begin
            // byte-order mark, then a dash, overline or full-block glyph
            add_bytes(3, 8'hEF, 8'hBB, 8'hBF);
            case (b)
                CH_BACKTICK: add_bytes(3, 8'hE2, 8'h80, 8'h92);
                CH_TILDE:    add_bytes(3, 8'hE2, 8'h80, 8'hBE);
                default:     add_bytes(3, 8'hE2, 8'h96, 8'h88);
            endcase
        end
        else if (b >= 8'h20 && b <= 8'h7F)
            add_bytes(1, b, 8'h00, 8'h00);
        else
            add_bytes(1, CH_QUESTION, 8'h00, 8'h00);
    endfunction

    function automatic void letter_bytes(input text_mode_t mode, input logic [7:0] b);
        logic [3:0][7:0] tails;
        logic            hit;
        hit   = 1'b1;
        tails = '0;
        if (mode == MODE_CEDIL)
        begin
            if (b == "c")
                add_bytes(2, 8'hC3, 8'hA7, 8'h00);
            else if (b == "C")
                add_bytes(2, 8'hC3, 8'h87, 8'h00);
            else
                glyph_bytes(b);
        end
        else
        begin
            // entry 0 grave, 1 acute, 2 circumflex, 3 diaeresis
            case (b)
                "a":     tails = {8'hA4, 8'hA2, 8'hA1, 8'hA0};
                "e":     tails = {8'hAB, 8'hAA, 8'hA9, 8'hA8};
                "i":     tails = {8'hAF, 8'hAE, 8'hAD, 8'hAC};
                "o":     tails = {8'hB6, 8'hB4, 8'hB3, 8'hB2};
                "u":     tails = {8'hBC, 8'hBB, 8'hBA, 8'hB9};
                "A":     tails = {8'h84, 8'h82, 8'h81, 8'h80};
                "E":     tails = {8'h8B, 8'h8A, 8'h89, 8'h88};
                "I":     tails = {8'h8F, 8'h8E, 8'h8D, 8'h8C};
                "O":     tails = {8'h96, 8'h94, 8'h93, 8'h92};
                "U":     tails = {8'h9C, 8'h9B, 8'h9A, 8'h99};
                default: hit = 1'b0;
            endcase
            if (hit)
                add_bytes(2, 8'hC3, tails[int'(mode) - int'(MODE_GRAVE)], 8'h00);
            else
                glyph_bytes(b);
        end
    endfunction

    function automatic void symbol_bytes(input logic [7:0] b);
        case (b)
            "#":  add_bytes(2, 8'hC2, 8'hA3, 8'h00);
            "$":  add_bytes(1, "$", 8'h00, 8'h00);
            "&":  add_bytes(1, "#", 8'h00, 8'h00);
            ",":  add_bytes(3, 8'hE2, 8'h86, 8'h90);
            "-":  add_bytes(3, 8'hE2, 8'h86, 8'h91);
            ".":  add_bytes(3, 8'hE2, 8'h86, 8'h92);
            "/":  add_bytes(3, 8'hE2, 8'h86, 8'h93);
            "0":  add_bytes(2, 8'hC2, 8'hB0, 8'h00);
            "1":  add_bytes(2, 8'hC2, 8'hB1, 8'h00);
            "8":  add_bytes(2, 8'hC3, 8'hB7, 8'h00);
            "<":  add_bytes(2, 8'hC2, 8'hBC, 8'h00);
            "=":  add_bytes(2, 8'hC2, 8'hBD, 8'h00);
            ">":  add_bytes(2, 8'hC2, 8'hBE, 8'h00);
            "j":  add_bytes(2, 8'hC5, 8'h92, 8'h00);
            "z":  add_bytes(2, 8'hC5, 8'h93, 8'h00);
            "{":  add_bytes(2, 8'hC3, 8'h9F, 8'h00);
            8'h27: add_bytes(2, 8'hC2, 8'hA7, 8'h00);
            default: ;  // unknown code is swallowed
        endcase
    endfunction

    function automatic void predict_text_byte(input logic [7:0] b);
        text_mode_t mode;
        utf8_beat_t beat;
        mode = text_mode;
        utf8_run.delete();
        if (b == CH_EOT)
        begin
            text_mode = MODE_NORMAL;
            add_bytes(1, 8'h00, 8'h00, 8'h00);
        end
        else
        begin
            case (mode)
                MODE_ACCENT:
                begin
                    text_mode = MODE_NORMAL;
                    case (b)
                        KEY_GRAVE: text_mode = MODE_GRAVE;
                        KEY_ACUTE: text_mode = MODE_ACUTE;
                        KEY_CIRC:  text_mode = MODE_CIRC;
                        KEY_UML:   text_mode = MODE_UML;
                        KEY_CEDIL: text_mode = MODE_CEDIL;
                        default:   symbol_bytes(b);
                    endcase
                end
                MODE_GRAVE, MODE_ACUTE, MODE_CIRC, MODE_UML, MODE_CEDIL:
                begin
                    text_mode = MODE_NORMAL;
                    letter_bytes(mode, b);
                end
                MODE_ESC:
                begin
                    if (b != CH_SPACE && b != CH_HASH)
                        text_mode = MODE_NORMAL;
                end
                MODE_CUR1:
                    text_mode = MODE_CUR2;
                MODE_CUR2:
                    text_mode = MODE_NORMAL;
                default:
                begin
                    text_mode = MODE_NORMAL;
                    case (b)
                        CH_ACCENT: text_mode = MODE_ACCENT;
                        CH_ESC:    text_mode = MODE_ESC;
                        CH_CURSOR: text_mode = MODE_CUR1;
                        default:   glyph_bytes(b);
                    endcase
                end
            endcase
        end
        foreach (utf8_run[i])
        begin
            beat.out_byte    = utf8_run[i];
            beat.last_of_run = (i == utf8_run.size() - 1);
            beat.end_of_text = (b == CH_EOT);
            pending_utf8.push_back(beat);
        end
    endfunction

    // ------------------------------------------------------------------
    // text_in driver
    // ------------------------------------------------------------------
    task automatic send_text_byte(input logic [7:0] b);
        while (sender_idle_on && $urandom_range(99) < 12)
        begin
            text_in_if.valid <= 1'b0;
            @(posedge clk);
        end
        text_in_if.valid   <= 1'b1;
        text_in_if.in_byte <= b;
        @(posedge clk);
        while (text_in_if.ready !== 1'b1)
            @(posedge clk);
        predict_text_byte(b);
        text_bytes_sent++;
    endtask

    function automatic logic [7:0] random_table_key();
        case ($urandom_range(4))
            0:       return KEY_GRAVE;
            1:       return KEY_ACUTE;
            2:       return KEY_CIRC;
            3:       return KEY_UML;
            default: return KEY_CEDIL;
        endcase
    endfunction

    function automatic logic [7:0] random_letter();
        case ($urandom_range(11))
            0:       return "a";
            1:       return "e";
            2:       return "i";
            3:       return "o";
            4:       return "u";
            5:       return "A";
            6:       return "E";
            7:       return "I";
            8:       return "O";
            9:       return "U";
            10:      return "c";
            default: return "C";
        endcase
    endfunction

    function automatic logic [7:0] random_symbol_key();
        case ($urandom_range(16))
            0:       return "#";
            1:       return "$";
            2:       return "&";
            3:       return ",";
            4:       return "-";
            5:       return ".";
            6:       return "/";
            7:       return "0";
            8:       return "1";
            9:       return "8";
            10:      return "<";
            11:      return "=";
            12:      return ">";
            13:      return "j";
            14:      return "z";
            15:      return "{";
            default: return 8'h27;
        endcase
    endfunction

    // one well-formed sequence with random content, or a stray byte
    task automatic send_random_sequence();
        int kind;
        int run_len;
        kind = $urandom_range(99);
        if (kind < 35)
            send_text_byte(8'($urandom_range(8'h7F, 8'h20)));
        else if (kind < 55)
        begin
            send_text_byte(CH_ACCENT);
            send_text_byte(random_table_key());
            if ($urandom_range(3) == 0)
                send_text_byte(8'($urandom_range(255, 1)));
            else
                send_text_byte(random_letter());
        end
        else if (kind < 70)
        begin
            send_text_byte(CH_ACCENT);
            if ($urandom_range(4) == 0)
                send_text_byte(8'($urandom_range(255, 1)));
            else
                send_text_byte(random_symbol_key());
        end
        else if (kind < 78)
        begin
            send_text_byte(CH_ESC);
            run_len = $urandom_range(3);
            repeat (run_len)
                send_text_byte($urandom_range(1) ? CH_SPACE : CH_HASH);
            send_text_byte(8'($urandom_range(255, 1)));
        end
        else if (kind < 85)
        begin
            send_text_byte(CH_CURSOR);
            send_text_byte(8'($urandom_range(255, 1)));
            send_text_byte(8'($urandom_range(255, 1)));
        end
        else if (kind < 90)
            send_text_byte(CH_EOT);
        else
            send_text_byte(8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------
    // utf8_out sink and checker
    // ------------------------------------------------------------------
    initial
    begin
        utf8_beat_t want;
        utf8_out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && utf8_out_if.valid === 1'b1 && utf8_out_if.ready === 1'b1)
            begin
                if (pending_utf8.size() == 0)
                begin
                    $error("out_byte: expected none, actual %h", utf8_out_if.out_byte);
                    error_count++;
                end
                else
                begin
                    want = pending_utf8.pop_front();
                    if (utf8_out_if.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, utf8_out_if.out_byte);
                        error_count++;
                    end
                    if (utf8_out_if.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %b, actual %b",
                               want.last_of_run, utf8_out_if.last_of_run);
                        error_count++;
                    end
                    if (utf8_out_if.end_of_text !== want.end_of_text)
                    begin
                        $error("end_of_text: expected %b, actual %b",
                               want.end_of_text, utf8_out_if.end_of_text);
                        error_count++;
                    end
                end
            end
            utf8_out_if.ready <= !(sink_stall_on && $urandom_range(99) < 12);
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_plain_text();
        send_text_byte(CH_SPACE);
        send_text_byte(8'h7D);
        send_text_byte(CH_BACKTICK);
        send_text_byte(CH_TILDE);
        send_text_byte(CH_DEL);
        send_text_byte(8'h01);
        send_text_byte(8'hFF);
    endtask

    task automatic test_accent_sequences();
        send_text_byte(CH_ACCENT);
        send_text_byte(KEY_GRAVE);
        send_text_byte("a");
        send_text_byte(CH_ACCENT);
        send_text_byte(KEY_CEDIL);
        send_text_byte("C");
        send_text_byte(CH_ACCENT);
        send_text_byte(",");
        // unknown symbol code disappears
        send_text_byte(CH_ACCENT);
        send_text_byte(8'h51);
        // accent byte where a letter belongs comes out as '?'
        send_text_byte(CH_ACCENT);
        send_text_byte(KEY_CIRC);
        send_text_byte(CH_ACCENT);
        // terminator drops the open sequence
        send_text_byte(CH_ACCENT);
        send_text_byte(KEY_UML);
        send_text_byte(CH_EOT);
    endtask

    task automatic test_escape_and_cursor();
        send_text_byte(CH_ESC);
        send_text_byte(CH_SPACE);
        send_text_byte(CH_HASH);
        send_text_byte(8'h5A);
        send_text_byte(CH_CURSOR);
        send_text_byte(CH_ACCENT);
        send_text_byte(CH_ESC);
        send_text_byte(CH_EOT);
    endtask

    task automatic test_back_to_back();
        int start;
        start          = text_bytes_sent;
        sender_idle_on = 1'b0;
        sink_stall_on  = 1'b0;
        while (text_bytes_sent - start < 80)
            send_random_sequence();
        sender_idle_on = 1'b1;
        sink_stall_on  = 1'b1;
    endtask

    task automatic test_random_stream();
        int start;
        start = text_bytes_sent;
        while (text_bytes_sent - start < 380)
            send_random_sequence();
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        text_in_if.valid   <= 1'b0;
        text_in_if.in_byte <= 8'h00;
        text_mode = MODE_NORMAL;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_text();
        test_accent_sequences();
        test_escape_and_cursor();
        test_back_to_back();
        test_random_stream();

        text_in_if.valid <= 1'b0;
        while (pending_utf8.size() != 0)
            @(posedge clk);
        // catch any stray transfer after the last expected one
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("videotex_text_to_utf8 regression: pass");
        else
            $display("videotex_text_to_utf8 regression: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("videotex_text_to_utf8 regression: fail");
        $finish;
    end

endmodule
